@@ rtl/core/ddsr_pkg.sv @@
// Package: shared types, constants and helpers of the replacement engine.
`default_nettype none
package ddsr_pkg;
   localparam int NUM_SETS_DEF    = 2048;
   localparam int NUM_WAYS_DEF    = 16;
   localparam int LEADER_SETS_DEF = 32;
   localparam int ADDR_BITS_DEF   = 48;
   localparam logic [9:0]  PSEL_MID  = 10'd512;
   localparam logic [9:0]  PSEL_MAX  = 10'd1023;
   localparam logic [15:0] LFSR_SEED = 16'h0001;
   localparam logic [15:0] LFSR_MASK = 16'hB400;
   localparam logic [1:0]  RRPV_FAR  = 2'd3;
   localparam logic [1:0]  RRPV_LONG = 2'd2;
   localparam logic [1:0]  RRPV_NEAR = 2'd0;
   localparam logic [1:0]  DEAD_FILL = 2'd2;
   localparam logic        MODE_VICTIM = 1'b0;
   localparam logic        MODE_UPDATE = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [10:0] set_index;
      logic [3:0]  way_index;
      logic [47:0] phys_address;
      logic        was_hit;
   } req_type;

   typedef struct packed {
      logic [3:0] victim_way;
      logic [9:0] policy_counter;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_STRIDE, ST_EXEC, ST_DECAY, ST_DONE
   } state_type;

   function automatic logic [15:0] lfsr_next(input logic [15:0] s);
      lfsr_next = s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/ddsr_front.sv @@
// Front part: request queue that accepts requests and classifies set and way.
`default_nettype none
module ddsr_front #(
   parameter int NUM_SETS = ddsr_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = ddsr_pkg::NUM_WAYS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire ddsr_pkg::req_type req_in,
   output logic                  q_valid,
   input  wire logic             q_take,
   output ddsr_pkg::req_type     q_item
);
   // two-entry queue; set and way are reduced to range at entry
   ddsr_pkg::req_type mem_ff [2];
   logic rd_ff, wr_ff;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   ddsr_pkg::req_type cls;
   logic do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign q_valid = cnt_ff != 2'd0;
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;
   assign q_item  = mem_ff[rd_ff];

   always_comb begin
      cls = req_in;
      cls.set_index = req_in.set_index & 11'(NUM_SETS - 1);
      cls.way_index = req_in.way_index & 4'(NUM_WAYS - 1);
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
      end
      if (do_push) mem_ff[wr_ff] <= cls;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !q_valid == 1'b0) else $error("full but empty");
   a_inc: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("count did not advance");
endmodule
`default_nettype wire

@@ rtl/core/ddsr_back.sv @@
// Back part: set-row memories, victim scan, update, duelling and decay sweep.
`default_nettype none
module ddsr_back #(
   parameter int NUM_SETS    = ddsr_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS    = ddsr_pkg::NUM_WAYS_DEF,
   parameter int LEADER_SETS = ddsr_pkg::LEADER_SETS_DEF,
   parameter int ADDR_BITS   = ddsr_pkg::ADDR_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_take,
   input  wire ddsr_pkg::req_type q_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_take,
   output ddsr_pkg::rsp_type      rsp_out
);
   localparam int SW = $clog2(NUM_SETS);
   localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int SB = ADDR_BITS + 1;
   localparam int DECAY = NUM_SETS * NUM_WAYS / 8;
   localparam int FW = $clog2(DECAY + 1);
   localparam int ROW = 2 * NUM_WAYS;

   // set rows: rrpv+dead per way, stride record per set
   logic [ROW-1:0]       rrpv_mem [NUM_SETS];
   logic [ROW-1:0]       dead_mem [NUM_SETS];
   logic [ADDR_BITS-1:0] pa_mem   [NUM_SETS];
   logic [SB-1:0]        ps_mem   [NUM_SETS];
   logic [1:0]           conf_mem [NUM_SETS];

   ddsr_pkg::state_type st_ff, st_in;
   ddsr_pkg::req_type it_ff;
   ddsr_pkg::rsp_type out_ff;
   logic [ROW-1:0] rr_ff, dd_ff, rr_w, dd_w;
   logic [ROW-1:0] dk_ff, dk_dec;
   logic [SW-1:0] dk_set_ff;
   logic dk_v_ff, rsp_v_ff, out_free, ld_out, fill_wrap;
   logic [ADDR_BITS-1:0] pa_ff;
   logic [SB-1:0] ps_ff, stride_ff;
   logic [1:0] conf_ff, conf_new_ff;
   logic [SW-1:0] sw_ff;
   logic [9:0] psel_ff;
   logic [FW-1:0] fill_ff;
   logic [15:0] lfsr_ff;
   logic [3:0] vic_ff;
   logic [SW-1:0] set_q;
   logic [WW-1:0] way_q;
   logic [ADDR_BITS-1:0] addr_q;
   logic [SB-1:0] stride_c;
   logic [1:0] conf_c;
   logic [3:0] vic_c;
   logic [1:0] top_c, add_c, ins_c, d_old;
   logic srl, brl, use_b, found_d;
   logic [15:0] lfsr_c;
   logic [9:0] psel_c;

   assign set_q  = it_ff.set_index[SW-1:0];
   assign way_q  = it_ff.way_index[WW-1:0];
   assign addr_q = it_ff.phys_address[ADDR_BITS-1:0];
   assign srl = set_q < SW'(LEADER_SETS);
   assign brl = !srl && set_q >= SW'(NUM_SETS - LEADER_SETS);
   // this fill completes a decay period
   assign fill_wrap = it_ff.mode == ddsr_pkg::MODE_UPDATE && !it_ff.was_hit &&
                      (fill_ff + FW'(1) >= FW'(DECAY));

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ddsr_pkg::ST_CLEAR:  if (sw_ff == SW'(NUM_SETS - 1)) st_in = ddsr_pkg::ST_IDLE;
         ddsr_pkg::ST_IDLE:   if (q_valid) st_in = ddsr_pkg::ST_READ;
         ddsr_pkg::ST_READ:   st_in = ddsr_pkg::ST_STRIDE;
         ddsr_pkg::ST_STRIDE: st_in = ddsr_pkg::ST_EXEC;
         ddsr_pkg::ST_EXEC:   st_in = fill_wrap ? ddsr_pkg::ST_DECAY : ddsr_pkg::ST_DONE;
         ddsr_pkg::ST_DECAY:  if (sw_ff == SW'(NUM_SETS - 1)) st_in = ddsr_pkg::ST_DONE;
         ddsr_pkg::ST_DONE:   if (out_free) st_in = ddsr_pkg::ST_IDLE;
         default:             st_in = ddsr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_take = st_ff == ddsr_pkg::ST_IDLE && q_valid;
      out_free = !rsp_v_ff || rsp_take;
      ld_out = st_ff == ddsr_pkg::ST_DONE && out_free;
      rsp_valid = rsp_v_ff;
      rsp_out = out_ff;
   end

   // stride detector
   always_comb begin
      stride_c = SB'({1'b0, addr_q} - {1'b0, pa_ff});
      if (stride_c == ps_ff && stride_c != '0)
         conf_c = (conf_ff == 2'd3) ? 2'd3 : conf_ff + 2'd1;
      else
         conf_c = (conf_ff == 2'd0) ? 2'd0 : conf_ff - 2'd1;
   end

   // decay of one registered row
   always_comb begin
      dk_dec = dk_ff;
      for (int w = 0; w < NUM_WAYS; w++)
         if (dk_ff[2*w +: 2] != 2'd0) dk_dec[2*w +: 2] = dk_ff[2*w +: 2] - 2'd1;
   end

   // victim scan and update of the row
   always_comb begin
      vic_c = '0; found_d = 1'b0; top_c = '0;
      rr_w = rr_ff; dd_w = dd_ff;
      lfsr_c = lfsr_ff; psel_c = psel_ff; ins_c = ddsr_pkg::RRPV_LONG;
      use_b = brl || (!srl && psel_ff >= ddsr_pkg::PSEL_MID);
      d_old = dd_ff[2*way_q +: 2];
      for (int w = NUM_WAYS - 1; w >= 0; w--)
         if (dd_ff[2*w +: 2] == 2'd0) begin
            vic_c = 4'(w); found_d = 1'b1;
         end
      for (int w = 0; w < NUM_WAYS; w++)
         if (rr_ff[2*w +: 2] > top_c) top_c = rr_ff[2*w +: 2];
      add_c = ddsr_pkg::RRPV_FAR - top_c;
      if (it_ff.mode == ddsr_pkg::MODE_VICTIM) begin
         if (!found_d) begin
            for (int w = 0; w < NUM_WAYS; w++)
               rr_w[2*w +: 2] = rr_ff[2*w +: 2] + add_c;
            for (int w = NUM_WAYS - 1; w >= 0; w--)
               if (rr_w[2*w +: 2] == ddsr_pkg::RRPV_FAR) vic_c = 4'(w);
         end
      end else if (it_ff.was_hit) begin
         vic_c = '0;
         dd_w[2*way_q +: 2] = (d_old == 2'd3) ? 2'd3 : d_old + 2'd1;
         rr_w[2*way_q +: 2] = ddsr_pkg::RRPV_NEAR;
      end else begin
         vic_c = '0;
         if (use_b) begin
            lfsr_c = ddsr_pkg::lfsr_next(lfsr_ff);
            ins_c = (lfsr_c[4:0] == 5'd0) ? ddsr_pkg::RRPV_NEAR : ddsr_pkg::RRPV_LONG;
         end
         if (conf_new_ff >= 2'd2) ins_c = ddsr_pkg::RRPV_FAR;
         rr_w[2*way_q +: 2] = ins_c;
         dd_w[2*way_q +: 2] = ddsr_pkg::DEAD_FILL;
         if (brl && psel_ff != 10'd0) psel_c = psel_ff - 10'd1;
         else if (srl && psel_ff != ddsr_pkg::PSEL_MAX) psel_c = psel_ff + 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ddsr_pkg::ST_CLEAR;
         sw_ff <= '0;
         psel_ff <= ddsr_pkg::PSEL_MID;
         fill_ff <= '0;
         lfsr_ff <= ddsr_pkg::LFSR_SEED;
         dk_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         dk_v_ff <= st_ff == ddsr_pkg::ST_DECAY;
         unique case (st_ff)
            ddsr_pkg::ST_CLEAR: begin
               rrpv_mem[sw_ff] <= {NUM_WAYS{ddsr_pkg::RRPV_FAR}};
               dead_mem[sw_ff] <= '0;
               pa_mem[sw_ff] <= '0;
               ps_mem[sw_ff] <= '0;
               conf_mem[sw_ff] <= '0;
               sw_ff <= sw_ff + SW'(1);
            end
            ddsr_pkg::ST_IDLE: begin
               it_ff <= q_item;
            end
            ddsr_pkg::ST_READ: begin
               rr_ff <= rrpv_mem[set_q];
               dd_ff <= dead_mem[set_q];
               pa_ff <= pa_mem[set_q];
               ps_ff <= ps_mem[set_q];
               conf_ff <= conf_mem[set_q];
            end
            ddsr_pkg::ST_STRIDE: begin
               stride_ff <= stride_c;
               conf_new_ff <= conf_c;
            end
            ddsr_pkg::ST_EXEC: begin
               vic_ff <= vic_c;
               rrpv_mem[set_q] <= rr_w;
               dead_mem[set_q] <= dd_w;
               psel_ff <= psel_c;
               lfsr_ff <= lfsr_c;
               sw_ff <= '0;
               if (it_ff.mode == ddsr_pkg::MODE_UPDATE) begin
                  pa_mem[set_q] <= addr_q;
                  ps_mem[set_q] <= stride_ff;
                  conf_mem[set_q] <= conf_new_ff;
                  if (!it_ff.was_hit) begin
                     if (fill_wrap) fill_ff <= '0;
                     else fill_ff <= fill_ff + FW'(1);
                  end
               end
            end
            ddsr_pkg::ST_DECAY: begin
               // read one row per cycle; it is written back decremented in the following cycle
               dk_ff <= dead_mem[sw_ff];
               dk_set_ff <= sw_ff;
               sw_ff <= sw_ff + SW'(1);
            end
            ddsr_pkg::ST_DONE: ;
            default: ;
         endcase
         if (dk_v_ff) dead_mem[dk_set_ff] <= dk_dec;
         if (ld_out) begin
            out_ff.victim_way <= vic_ff;
            out_ff.policy_counter <= psel_ff;
            rsp_v_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   a_take: assert property (@(posedge clock) disable iff (reset)
      q_take |=> st_ff == ddsr_pkg::ST_READ) else $error("take without read");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_take) |=> rsp_valid && $stable(rsp_out))
      else $error("result changed while held");
   a_lfsr: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != 16'd0) else $error("lfsr stuck at zero");
endmodule
`default_nettype wire

@@ rtl/core/drrip_dead_block_streaming_replacement.sv @@
// Top level of the DRRIP replacement engine with dead-block and stream detection.
// Usage:
//  - Requests enter through push/full (accepted when push high, full low);
//    req_data carries mode, set, way, address and hit flag.
//  - Each request yields one result on rsp_data while empty is low; take it
//    with pop. A victim request returns the chosen way, an update returns 0;
//    both return the duelling counter after the request.
//  - A request passes through the steps take, read row, stride compare, execute
//    and load output register; the back part handles one request at a time and
//    takes the next from the front queue only once the result has been loaded
//    into the output register.
//  - Every NUM_SETS*NUM_WAYS/8 fills a decay sweep walks all NUM_SETS rows,
//    one per cycle, before that request's result appears.
//  - Reset: synchronous; afterwards a clearing pass over all NUM_SETS rows
//    initialises the row memories. The front queue keeps accepting two requests.
//  - Stalls: an unpopped result is held in the output register; the back part
//    finishes the next request and holds it, and the two-entry front queue
//    absorbs incoming requests until it reports full.
`default_nettype none
module drrip_dead_block_streaming_replacement #(
   parameter int NUM_SETS    = ddsr_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS    = ddsr_pkg::NUM_WAYS_DEF,
   parameter int LEADER_SETS = ddsr_pkg::LEADER_SETS_DEF,
   parameter int ADDR_BITS   = ddsr_pkg::ADDR_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire ddsr_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output ddsr_pkg::rsp_type      rsp_data
);
   logic q_valid, q_take, rsp_valid;
   ddsr_pkg::req_type q_item;

   ddsr_front #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_front (
      .clock, .reset, .push, .full, .req_in(req_data),
      .q_valid, .q_take, .q_item);

   ddsr_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
      .LEADER_SETS(LEADER_SETS), .ADDR_BITS(ADDR_BITS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_item,
      .rsp_valid, .rsp_take(pop), .rsp_out(rsp_data));

   assign empty = !rsp_valid;
endmodule
`default_nettype wire

@@ tb/sv/tb_drrip_dead_block_streaming_replacement.sv @@
// Self-checking testbench of the DRRIP replacement engine with dead-block and stream detection.
`default_nettype none
module tb_drrip_dead_block_streaming_replacement;
   import ddsr_pkg::*;

   localparam int SETS    = NUM_SETS_DEF;
   localparam int WAYS    = NUM_WAYS_DEF;
   localparam int LEADERS = LEADER_SETS_DEF;
   localparam int DECAY_FILLS = SETS * WAYS / 8;
   localparam int RANDOM_REQUESTS = 1800;

   // Replacement state mirror: works out the response of every accepted request
   // and holds it until the engine delivers its own.
   class replacement_mirror;
      logic [1:0]  rrpv [SETS*WAYS];
      logic [1:0]  dead [SETS*WAYS];
      logic [47:0] prev_addr [SETS];
      logic [48:0] last_stride [SETS];
      logic [1:0]  confidence [SETS];
      logic [9:0]  psel;
      int unsigned fills;
      logic [15:0] lfsr;
      rsp_type     awaited [$];
      int unsigned mismatches, responses, victims, updates, decays, streamed;

      function new();
         for (int i = 0; i < SETS*WAYS; i++) begin
            rrpv[i] = RRPV_FAR;
            dead[i] = 2'd0;
         end
         for (int i = 0; i < SETS; i++) begin
            prev_addr[i] = '0;
            last_stride[i] = '0;
            confidence[i] = 2'd0;
         end
         psel = PSEL_MID;
         fills = 0;
         lfsr = LFSR_SEED;
         mismatches = 0;
         responses = 0;
         victims = 0;
         updates = 0;
         decays = 0;
         streamed = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Advance the engine state by one accepted request and queue its response.
      function void log_request(req_type r);
         int unsigned s, base, idx;
         logic [48:0] stride;
         logic [1:0]  ins, top;
         logic [3:0]  way;
         bit          found, srrip_lead, brrip_lead;
         rsp_type     rsp;
         s = r.set_index;
         base = s * WAYS;
         way = '0;
         if (r.mode == MODE_VICTIM) begin
            victims++;
            found = 0;
            for (int w = 0; w < WAYS; w++)
               if (!found && dead[base+w] == 2'd0) begin
                  way = 4'(w);
                  found = 1;
               end
            if (!found) begin
               // age the whole row by the same step so the oldest way reaches distant
               top = 2'd0;
               for (int w = 0; w < WAYS; w++)
                  if (rrpv[base+w] > top) top = rrpv[base+w];
               for (int w = 0; w < WAYS; w++)
                  rrpv[base+w] = rrpv[base+w] + (RRPV_FAR - top);
               for (int w = 0; w < WAYS; w++)
                  if (!found && rrpv[base+w] == RRPV_FAR) begin
                     way = 4'(w);
                     found = 1;
                  end
            end
         end else begin
            updates++;
            idx = base + r.way_index;
            stride = {1'b0, r.phys_address} - {1'b0, prev_addr[s]};
            if (stride == last_stride[s] && stride != '0) begin
               if (confidence[s] != 2'd3) confidence[s]++;
            end else if (confidence[s] != 2'd0) begin
               confidence[s]--;
            end
            last_stride[s] = stride;
            prev_addr[s] = r.phys_address;
            if (r.was_hit) begin
               if (dead[idx] != 2'd3) dead[idx]++;
               rrpv[idx] = RRPV_NEAR;
            end else begin
               if (dead[idx] != 2'd0) dead[idx]--;
               srrip_lead = s < LEADERS;
               brrip_lead = !srrip_lead && s >= SETS - LEADERS;
               ins = RRPV_LONG;
               if (brrip_lead || (!srrip_lead && psel >= PSEL_MID)) begin
                  lfsr = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);
                  if (lfsr[4:0] == 5'd0) ins = RRPV_NEAR;
               end
               if (confidence[s] >= 2'd2) begin
                  ins = RRPV_FAR;
                  streamed++;
               end
               rrpv[idx] = ins;
               dead[idx] = DEAD_FILL;
               if (brrip_lead) begin
                  if (psel != 10'd0) psel--;
               end else if (srrip_lead) begin
                  if (psel != PSEL_MAX) psel++;
               end
               fills++;
               if (fills >= DECAY_FILLS) begin
                  fills = 0;
                  decays++;
                  for (int i = 0; i < SETS*WAYS; i++)
                     if (dead[i] != 2'd0) dead[i]--;
               end
            end
         end
         rsp.victim_way = way;
         rsp.policy_counter = psel;
         awaited.push_back(rsp);
      endfunction

      function void compare_response(rsp_type got);
         rsp_type want;
         responses++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response %0d arrived with nothing outstanding: way %0d psel %0d",
                        responses, got.victim_way, got.policy_counter);
            return;
         end
         want = awaited.pop_front();
         if (got.victim_way !== want.victim_way || got.policy_counter !== want.policy_counter)
         begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response %0d: way exp %0d got %0d, psel exp %0d got %0d",
                        responses, want.victim_way, got.victim_way,
                        want.policy_counter, got.policy_counter);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   replacement_mirror mirror;
   int unsigned accepted;
   bit          stimulus_done;

   // Per-set stream generators for the well-formed part of the stimulus.
   logic [47:0] stream_addr [16];
   logic [47:0] stream_step [16];
   logic [10:0] hot_sets [16];

   drrip_dead_block_streaming_replacement DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one request and hold it until the engine takes it; push stays high
   // on return so that a back-to-back request needs no second assignment.
   task automatic send_request(req_type r);
      req_data <= r;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      mirror.log_request(r);
      accepted++;
   endtask

   task automatic go_quiet(int unsigned cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop the request line and hold until every outstanding response is back.
   task automatic drain();
      go_quiet(1);
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   function automatic req_type make_update(logic [10:0] s, logic [3:0] w, logic [47:0] a,
                                           logic h);
      req_type r;
      r.mode = MODE_UPDATE;
      r.set_index = s;
      r.way_index = w;
      r.phys_address = a;
      r.was_hit = h;
      return r;
   endfunction

   function automatic req_type make_victim(logic [10:0] s);
      req_type r;
      r.mode = MODE_VICTIM;
      r.set_index = s;
      r.way_index = 4'($urandom());
      r.phys_address = 48'({$urandom(), $urandom()});
      r.was_hit = 1'($urandom());
      return r;
   endfunction

   // Mostly strided traffic on a small pool of sets so rows fill up and ageing
   // is reached; the rest is scattered noise across the whole address space.
   function automatic req_type make_random();
      req_type r;
      int unsigned k, pick;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 15);
      if (pick < 8) begin
         r = make_update(11'($urandom()), 4'($urandom()), 48'({$urandom(), $urandom()}),
                         1'($urandom()));
         r.mode = 1'($urandom());
      end else if (pick < 40) begin
         r = make_victim(hot_sets[k]);
      end else begin
         if ($urandom_range(0, 9) < 8) begin
            stream_addr[k] = stream_addr[k] + stream_step[k];
         end else begin
            stream_addr[k] = 48'({$urandom(), $urandom()});
            stream_step[k] = 48'($urandom_range(1, 4) * 64);
            if ($urandom_range(0, 1)) stream_step[k] = -stream_step[k];
         end
         r = make_update(hot_sets[k], 4'($urandom()), stream_addr[k],
                         $urandom_range(0, 9) < 3);
      end
      return r;
   endfunction

   // Sender: directed opening, then bursts of random requests with gaps.
   initial begin
      int unsigned burst, gap;
      mirror = new();
      accepted = 0;
      stimulus_done = 0;
      burst = 0;
      reset <= 1'b1;
      push <= 1'b0;
      req_data <= '0;
      for (int i = 0; i < 16; i++) begin
         stream_addr[i] = 48'({$urandom(), $urandom()});
         stream_step[i] = 48'd64;
      end
      hot_sets = '{11'd0, 11'd1, 11'd31, 11'd32, 11'd33, 11'd1023, 11'd1024, 11'd1500,
                   11'd2014, 11'd2015, 11'd2016, 11'd2017, 11'd2047, 11'd700, 11'd5, 11'd9};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fresh row: the lowest way with a clear dead counter wins
      send_request(make_victim(11'd2047));
      // extremes of every field, on leader and follower sets
      send_request(make_update(11'd0, 4'd0, 48'h0, 1'b0));
      send_request(make_update(11'd2047, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b0));
      send_request(make_update(11'd1000, 4'd7, 48'h8000_0000_0000, 1'b1));
      send_request(make_update(11'd1000, 4'd8, 48'h0000_0000_0001, 1'b0));
      // steady stride until the set counts as streaming and inserts distant
      for (int i = 1; i <= 5; i++)
         send_request(make_update(11'd5, 4'(i), 48'(48'h40 * i), 1'b0));
      // fill a whole row so the victim search falls through to ageing
      for (int w = 0; w < WAYS; w++)
         send_request(make_update(11'd7, 4'(w), 48'({$urandom(), $urandom()}), 1'b0));
      send_request(make_victim(11'd7));
      send_request(make_victim(11'd7));
      drain();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (burst == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) go_quiet(gap);
            burst = $urandom_range(1, 40);
         end
         // hold off once mid-run until the engine has emptied completely
         if (i == RANDOM_REQUESTS / 2) drain();
         send_request(make_random());
         burst--;
      end
      go_quiet(1);
      stimulus_done = 1;
   end

   // Receiver: pop follows a stall style redrawn at random from four, plus one long hold-off.
   initial begin
      int unsigned cycle, hold, style;
      bit held_once;
      pop <= 1'b0;
      cycle = 0;
      hold = 0;
      held_once = 0;
      style = 0;
      forever begin
         @(posedge clock);
         if (pop && !empty) mirror.compare_response(rsp_data);
         cycle++;
         if (cycle % 64 == 0) style = $urandom_range(0, 3);
         if (!held_once && accepted >= 400) begin
            held_once = 1;
            hold = 500;
         end
         if (hold != 0) begin
            hold--;
            pop <= 1'b0;
         end else begin
            case (style)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               2: pop <= ($urandom_range(0, 4) == 0);
               default: pop <= (cycle % 8) < 5;
            endcase
         end
      end
   end

   // Wrap-up: wait for every response, allow trailing cycles, then report.
   initial begin
      @(posedge clock);
      while (!stimulus_done || mirror.pending() != 0) @(posedge clock);
      repeat (3 * SETS) @(posedge clock);
      $display("Run: %0d requests (%0d victim, %0d update), %0d responses, %0d stream inserts,",
               accepted, mirror.victims, mirror.updates, mirror.responses, mirror.streamed);
      $display("     %0d decay sweeps, final duelling counter %0d, %0d mismatches",
               mirror.decays, mirror.psel, mirror.mismatches);
      if (mirror.mismatches == 0 && mirror.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout with %0d responses outstanding", mirror.pending());
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
